// ----- hw/rtl/dce_pkg.sv -----
// Package: shared types and constants for the delimited column extractor.
package dce_pkg;

    localparam logic [7:0] BAR_CODE       = 8'h7C;
    localparam logic [7:0] BACKSLASH_CODE = 8'h5C;
    localparam logic [7:0] NEWLINE_CODE   = 8'h0A;

    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_COLUMN   = 2'd0,
        CFG_STRIP_ENCLOSING = 2'd1,
        CFG_VALUE_LIMIT     = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_ABSENT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] target_column;
        logic       strip_enclosing;
        logic [9:0] value_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t item;
    } push_t;

endpackage

// ----- hw/rtl/dce_if.sv -----
// Interfaces: byte input channel and result output channel.
interface dce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface dce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ----- hw/rtl/dce_parse.sv -----
// Parser: line/field state and the per-byte step that produces at most one result.
module dce_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  dce_pkg::cfg_t   cfg,
    output dce_pkg::push_t  push
);
    import dce_pkg::*;

    logic [7:0] field_number_reg,  field_number_next;
    logic       escape_seen_reg,   escape_seen_next;
    logic [7:0] held_char_reg,     held_char_next;
    logic       held_valid_reg,    held_valid_next;
    logic       lead_dropped_reg,  lead_dropped_next;
    logic [9:0] emitted_count_reg, emitted_count_next;
    logic       line_finished_reg, line_finished_next;

    logic is_nl;
    logic is_bar;
    logic in_target;
    logic under_limit;

    assign is_nl       = (in_byte == NEWLINE_CODE);
    assign is_bar      = (in_byte == BAR_CODE) && !escape_seen_reg;
    assign in_target   = (field_number_reg == cfg.target_column);
    assign under_limit = (emitted_count_reg < cfg.value_limit);

    always_comb
    begin
        field_number_next  = field_number_reg;
        escape_seen_next   = escape_seen_reg;
        held_char_next     = held_char_reg;
        held_valid_next    = held_valid_reg;
        lead_dropped_next  = lead_dropped_reg;
        emitted_count_next = emitted_count_reg;
        line_finished_next = line_finished_reg;
        push.valid         = 1'b0;
        push.item.out_byte = 8'h00;
        push.item.kind     = KIND_VALUE;
        push.item.last     = 1'b0;

        if (accept)
        begin
            escape_seen_next = (in_byte == BACKSLASH_CODE);
            if (line_finished_reg)
            begin
                if (is_nl)
                begin
                    field_number_next  = 8'd1;
                    emitted_count_next = 10'd0;
                    line_finished_next = 1'b0;
                    held_char_next     = 8'h00;
                    held_valid_next    = 1'b0;
                    lead_dropped_next  = 1'b0;
                end
            end
            else if (is_nl || is_bar)
            begin
                // field ends: hold is discarded in every case
                held_char_next    = 8'h00;
                held_valid_next   = 1'b0;
                lead_dropped_next = 1'b0;
                if (in_target || is_nl)
                begin
                    push.valid     = 1'b1;
                    push.item.kind = in_target ? KIND_DONE : KIND_ABSENT;
                    push.item.last = 1'b1;
                end
                if (is_nl)
                begin
                    field_number_next  = 8'd1;
                    emitted_count_next = 10'd0;
                    line_finished_next = 1'b0;
                end
                else if (in_target)
                begin
                    line_finished_next = 1'b1;
                end
                else if (field_number_reg != 8'hFF)
                begin
                    field_number_next = field_number_reg + 8'd1;
                end
            end
            else if (in_target)
            begin
                if (cfg.strip_enclosing)
                begin
                    if (!lead_dropped_reg)
                    begin
                        lead_dropped_next = 1'b1;
                    end
                    else
                    begin
                        if (held_valid_reg && under_limit)
                        begin
                            push.valid         = 1'b1;
                            push.item.out_byte = held_char_reg;
                            emitted_count_next = emitted_count_reg + 10'd1;
                        end
                        held_char_next  = in_byte;
                        held_valid_next = 1'b1;
                    end
                end
                else if (under_limit)
                begin
                    push.valid         = 1'b1;
                    push.item.out_byte = in_byte;
                    emitted_count_next = emitted_count_reg + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_number_reg  <= 8'd1;
            escape_seen_reg   <= 1'b0;
            held_char_reg     <= 8'h00;
            held_valid_reg    <= 1'b0;
            lead_dropped_reg  <= 1'b0;
            emitted_count_reg <= 10'd0;
            line_finished_reg <= 1'b0;
        end
        else
        begin
            field_number_reg  <= field_number_next;
            escape_seen_reg   <= escape_seen_next;
            held_char_reg     <= held_char_next;
            held_valid_reg    <= held_valid_next;
            lead_dropped_reg  <= lead_dropped_next;
            emitted_count_reg <= emitted_count_next;
            line_finished_reg <= line_finished_next;
        end
    end

endmodule

// ----- hw/rtl/dce_skid.sv -----
// Output stage: two-entry result queue that decouples the parser from the sink.
module dce_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  dce_pkg::push_t  push,
    output logic            space,
    dce_out_if.source       out_ch
);
    import dce_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;
    result_t    head;

    assign space  = (count_reg != 2'd2);
    assign pop    = out_ch.valid && out_ch.ready;
    assign head   = entry_reg[rd_ptr_reg];

    assign out_ch.valid    = (count_reg != 2'd0);
    assign out_ch.out_byte = head.out_byte;
    assign out_ch.kind     = head.kind;
    assign out_ch.last     = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/delimited_column_extractor.sv -----
// Top level: delimited column extractor with config registers, parser and output queue.
//
//  channel   direction  payload                       transaction when
//  in_ch     sink       in_byte[7:0]                  valid & ready
//  out_ch    source     out_byte[7:0] kind[1:0] last  valid & ready
//  cfg       write      cfg_index[1:0] cfg_data[9:0]  cfg_we
//
// One byte per cycle while the queue has space: each accepted byte is parsed in
// the cycle it arrives and its result (if any) is written to the output queue,
// visible the next cycle.
// rst_n (async, active low) clears line state, the queue and the registers to
// target_column=1, strip_enclosing=0, value_limit=255.
// in_ch.ready drops only while both queue entries are full.
module delimited_column_extractor (
    input  logic                               clk,
    input  logic                               rst_n,
    dce_in_if.sink                             in_ch,
    dce_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [dce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dce_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dce_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    push_t push;
    logic  space;
    logic  accept;

    // ready follows queue space; the parser never needs to stall otherwise
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    // register writes; an unused index is ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TARGET_COLUMN:   cfg_next.target_column   = cfg_data[7:0];
                CFG_STRIP_ENCLOSING: cfg_next.strip_enclosing = cfg_data[0];
                CFG_VALUE_LIMIT:     cfg_next.value_limit     = cfg_data[9:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_column   <= 8'd1;
            cfg_reg.strip_enclosing <= 1'b0;
            cfg_reg.value_limit     <= 10'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // per-byte field tracking, strip hold and limit count
    dce_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_ch.in_byte),
        .cfg     (cfg_reg),
        .push    (push)
    );

    // result queue toward the sink
    dce_skid u_skid (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space  (space),
        .out_ch (out_ch)
    );

endmodule

// ----- hw/rtl/dce_checker.sv -----
// Checker: port-level assertions on the result channel, bound to the top level.
module dce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] kind,
    input logic       last
);
    import dce_pkg::*;

    // only three result kinds exist
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_VALUE || kind == KIND_DONE || kind == KIND_ABSENT))
        else $error("illegal result kind");

    // value bytes never close the run
    a_value_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_VALUE) |-> !last)
        else $error("value byte flagged last");

    // closing items carry last and a zero byte
    a_close_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_VALUE) |-> (last && out_byte == 8'h00))
        else $error("closing item malformed");

    // a stalled result stays offered
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(out_byte)))
        else $error("stalled result dropped or changed");

endmodule

bind delimited_column_extractor dce_checker u_dce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .kind      (out_ch.kind),
    .last      (out_ch.last)
);
